FILE: rtl/pwc_pkg.sv
// pwc_pkg: shared types and constants for the pulse width capture block
// depends on nothing; imported by pwc_bit_alu, pwc_divider and the top level
`default_nettype none

package pwc_pkg;

  // data widths
  localparam int unsigned DataW  = 32;
  localparam int unsigned ResW   = 16;
  localparam int unsigned BitCntW = $clog2(DataW);

  // command codes
  typedef enum logic [1:0] {
    CmdEdge       = 2'd0,
    CmdReadLatest = 2'd1,
    CmdReadAvg    = 2'd2
  } cmd_e;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StEdge = 4'b0010,
    StDiv  = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  // one bit slice handed to the serial unit each cycle
  typedef struct packed {
    logic en;
    logic first;
    logic t_bit;
    logic start_bit;
    logic sum_bit;
    logic cnt_bit;
  } alu_in_t;

  // bits produced by the serial unit in the same cycle
  typedef struct packed {
    logic width_bit;
    logic sum_bit;
    logic cnt_bit;
  } alu_out_t;

  // divider control and status
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/pwc_bit_alu.sv
// pwc_bit_alu: bit-serial width subtract, sum accumulate and count increment
// depends on pwc_pkg; one bit of each operand per cycle while en is high, lsb first
`default_nettype none

module pwc_bit_alu (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pwc_pkg::alu_in_t  alu_i,
  output pwc_pkg::alu_out_t      alu_o
);
  import pwc_pkg::*;

  logic borrow_q, borrow_d;
  logic carry_q, carry_d;
  logic inc_q, inc_d;
  logic b_in, c_in, i_in;
  logic w_bit;

  // carries restart on the first bit
  assign b_in = alu_i.first ? 1'b0 : borrow_q;
  assign c_in = alu_i.first ? 1'b0 : carry_q;
  assign i_in = alu_i.first ? 1'b1 : inc_q;

  // width = time - start
  assign w_bit    = alu_i.t_bit ^ alu_i.start_bit ^ b_in;
  assign borrow_d = (~alu_i.t_bit & alu_i.start_bit) |
                    (~(alu_i.t_bit ^ alu_i.start_bit) & b_in);

  // sum = sum + width
  assign carry_d = (alu_i.sum_bit & w_bit) | (alu_i.sum_bit & c_in) | (w_bit & c_in);

  // count = count + 1
  assign inc_d = alu_i.cnt_bit & i_in;

  always_comb begin
    alu_o.width_bit = w_bit;
    alu_o.sum_bit   = alu_i.sum_bit ^ w_bit ^ c_in;
    alu_o.cnt_bit   = alu_i.cnt_bit ^ i_in;
  end

  // carry flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      borrow_q <= 1'b0;
      carry_q  <= 1'b0;
      inc_q    <= 1'b0;
    end else if (alu_i.en) begin
      borrow_q <= borrow_d;
      carry_q  <= carry_d;
      inc_q    <= inc_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pwc_divider.sv
// pwc_divider: restoring divider, one quotient bit per cycle
// depends on pwc_pkg; divisor must be nonzero, quotient valid when done is high
`default_nettype none

module pwc_divider (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire pwc_pkg::div_ctrl_t         ctrl_i,
  input  wire logic [pwc_pkg::DataW-1:0]  dividend_i,
  input  wire logic [pwc_pkg::DataW-1:0]  divisor_i,
  output pwc_pkg::div_stat_t              stat_o,
  output logic      [pwc_pkg::DataW-1:0]  quotient_o
);
  import pwc_pkg::*;

  logic [DataW-1:0]   rem_q, rem_d;
  logic [DataW-1:0]   quo_q, quo_d;
  logic [DataW-1:0]   div_q;
  logic [BitCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DataW:0]     rem_sh;
  logic [DataW+1:0]   trial;
  logic               ge;

  // shift in the next dividend bit and try the subtract
  assign rem_sh = {rem_q, quo_q[DataW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, div_q};
  assign ge     = ~trial[DataW+1];
  assign rem_d  = ge ? trial[DataW-1:0] : rem_sh[DataW-1:0];
  assign quo_d  = {quo_q[DataW-2:0], ge};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == BitCntW'(DataW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

`default_nettype wire

FILE: rtl/pwc_pulse_width_capture.sv
// pwm_pulse_width_capture: high-pulse width capture with latest and average reads
// Depends on pwc_pkg, pwc_bit_alu and pwc_divider.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) takes one request: cmd_i, level_high_i
//   and time_us_i. Edge requests give no result; each read request gives exactly one
//   result on the output channel (out_valid_o / out_ready_i): width_us_o and
//   was_average_o.
//   Handling per request:
//     rising edge, ignored falling edge, unused command: handled in StIdle, which it never leaves
//     falling edge with a pulse pending: runs in StEdge, paced by the bit-serial
//       subtract/accumulate unit that walks the 32-bit words one bit a cycle
//     latest read: the result goes through StOut into the output register, then StIdle
//     average read: through StDiv, paced by the restoring divider (one quotient bit a
//       cycle), then StOut; straight to StOut when no width has been counted
//   The output register holds one result. While the receiver stalls, edge requests
//   keep being taken; a read waits in the sequencer until the output register frees.
//   Reset clears the capture state: no pulse pending, latest width, sum and count zero.
`default_nettype none

module pwm_pulse_width_capture (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                cmd_i,
  input  wire logic                      level_high_i,
  input  wire logic [pwc_pkg::DataW-1:0] time_us_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [pwc_pkg::ResW-1:0]  width_us_o,
  output logic                           was_average_o
);
  import pwc_pkg::*;

  state_e             state_q, state_d;
  logic [DataW-1:0]   start_q, last_q, sum_q, count_q, time_sh_q;
  logic [BitCntW-1:0] bit_cnt_q;
  logic [ResW-1:0]    res_q;
  logic               res_avg_q;
  logic               out_valid_q;
  logic [ResW-1:0]    width_q;
  logic               was_avg_q;
  logic               accept;
  cmd_e               cmd;
  logic               out_free;
  logic               last_bit;
  alu_in_t            alu_in;
  alu_out_t           alu_out;
  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [DataW-1:0]   quotient;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i & in_ready_o;
  assign cmd        = cmd_e'(cmd_i);
  assign out_free   = ~out_valid_q | out_ready_i;
  assign last_bit   = (bit_cnt_q == BitCntW'(DataW - 1));

  // serial unit hookup
  always_comb begin
    alu_in.en        = (state_q == StEdge);
    alu_in.first     = (bit_cnt_q == '0);
    alu_in.t_bit     = time_sh_q[0];
    alu_in.start_bit = start_q[0];
    alu_in.sum_bit   = sum_q[0];
    alu_in.cnt_bit   = count_q[0];
  end

  pwc_bit_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .alu_i  (alu_in),
    .alu_o  (alu_out)
  );

  // divider launch on an average read with a nonzero count
  assign div_ctrl.start = accept & (cmd == CmdReadAvg) & (count_q != '0);

  pwc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          case (cmd)
            CmdEdge: begin
              if (!level_high_i && start_q != '0) state_d = StEdge;
            end
            CmdReadLatest: state_d = StOut;
            CmdReadAvg:    state_d = (count_q != '0) ? StDiv : StOut;
            default:       state_d = StIdle;
          endcase
        end
      end
      StEdge: if (last_bit) state_d = StIdle;
      StDiv:  if (div_stat.done) state_d = StOut;
      StOut:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bit_cnt_q <= '0;
      start_q   <= '0;
      last_q    <= '0;
      sum_q     <= '0;
      count_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StIdle: begin
          bit_cnt_q <= '0;
          if (accept) begin
            case (cmd)
              CmdEdge: if (level_high_i) start_q <= time_us_i;
              CmdReadLatest: last_q <= '0;
              CmdReadAvg: begin
                sum_q   <= '0;
                count_q <= '0;
              end
              default: ;
            endcase
          end
        end
        StEdge: begin
          // rotate operands, new bits enter at the top
          bit_cnt_q <= bit_cnt_q + 1'b1;
          start_q   <= last_bit ? '0 : {start_q[0], start_q[DataW-1:1]};
          last_q    <= {alu_out.width_bit, last_q[DataW-1:1]};
          sum_q     <= {alu_out.sum_bit, sum_q[DataW-1:1]};
          count_q   <= {alu_out.cnt_bit, count_q[DataW-1:1]};
        end
        StDiv, StOut: ;
        default: ;
      endcase
    end
  end

  // time shift register and pending result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      time_sh_q <= time_us_i;
      res_avg_q <= (cmd == CmdReadAvg);
      res_q     <= (cmd == CmdReadLatest) ? last_q[ResW-1:0] : '0;
    end else begin
      if (state_q == StEdge) time_sh_q <= {1'b0, time_sh_q[DataW-1:1]};
      if (state_q == StDiv && div_stat.done) res_q <= quotient[ResW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StOut && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StOut && out_free) begin
      width_q   <= res_q;
      was_avg_q <= res_avg_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign width_us_o    = width_q;
  assign was_average_o = was_avg_q;

endmodule

`default_nettype wire
